// File: rtl/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer package
// Shared widths, constants, codes and the command and status structs that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int OP_W      = 2;
  localparam int INDEX_W   = 8;
  localparam int PITCH_W   = 16;
  localparam int DIVIDER_W = 8;
  localparam int MS_W      = 19;
  localparam int TEMPO_W   = 10;
  localparam int COUNT_W   = 9;
  localparam int POS_W     = 8;
  localparam int ENTRY_W   = PITCH_W + DIVIDER_W;

  // Serial divider: dividend width, divisor width and two bits per cycle.
  localparam int DVD_W     = 22;
  localparam int DSR_W     = 10;
  localparam int DIV_STEPS = DVD_W / 2;

  localparam int WHOLE_NOTE_MS = 240000;
  localparam int TONE_DIVISOR  = 10;
  localparam logic [MS_W-1:0] ELAPSED_MAX = {MS_W{1'b1}};

  // Division by ten as a multiply by ceil(2^26 / 10) and a shift by 26. This
  // is exact for every dividend below 2^22, which covers nine times the
  // longest note.
  localparam int                 RECIP_W    = 23;
  localparam logic [RECIP_W-1:0] TONE_RECIP = 23'd6710887;
  localparam int                 TONE_SHIFT = 26;

  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 10'd120;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd1;

  typedef enum logic [0:0] {
    CFG_TEMPO      = 1'b0,
    CFG_NOTE_COUNT = 1'b1
  } cfg_index_e;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DSEL_WHOLE,
    DSEL_NOTE,
    DSEL_MOD
  } dsel_e;

  typedef struct packed {
    logic [DIVIDER_W-1:0] divider;
    logic [PITCH_W-1:0]   pitch;
  } note_entry_t;

  typedef struct packed {
    logic  latch;
    logic  ram_wr;
    logic  ram_rd;
    logic  start_play;
    logic  stop_play;
    logic  tick;
    logic  mod_ld;
    logic  entry_ld;
    logic  len_zero;
    logic  len_ld;
    logic  tone_ld;
    logic  div_start;
    dsel_e dsel;
    logic  result_ld;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic playing;
    logic reached;
    logic mod_needed;
    logic div_zero;
    logic pitch_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/melody_tone_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer
// Plays a table of pitch and divider pairs, one tick request per millisecond.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one request (write note, start, stop or
// tick) and the output channel returns exactly one result per request.
// Tempo and note count are to be written through the plain configuration
// port only while no request is in flight; the block does not enforce this.
// Flow: write, stop and ticks that do not end a note go from the latched
// request straight to the result. A start, or a tick that moves to the next
// note, reads the note table and runs the shared 2-bit-per-cycle divider
// twice (whole note, then note length); nine tenths of the length comes from
// a reciprocal multiply. A zero divider skips both divisions, and a rest
// skips the multiply. A position wrap after the note count was lowered adds
// one more division.
// Throughput: one request at a time; the next is accepted the cycle after a
// result is loaded. A finished result waits in the output register, and the
// next request is accepted meanwhile; it finishes once the receiver has
// taken the earlier one.
// Reset clears playback to idle at note 0, tempo 120 and note count 1; the
// note table is not cleared.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_core #(
  parameter int NOTE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [mts_pkg::OP_W-1:0]             operation_i,
  input  logic [mts_pkg::INDEX_W-1:0]          note_index_i,
  input  logic [mts_pkg::PITCH_W-1:0]          pitch_i,
  input  logic signed [mts_pkg::DIVIDER_W-1:0] divider_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 note_started_o,
  output logic [mts_pkg::PITCH_W-1:0]          tone_pitch_o,
  output logic [mts_pkg::MS_W-1:0]             tone_ms_o,
  output logic                                 silence_o,
  output logic                                 playing_o,
  output logic [mts_pkg::POS_W-1:0]            position_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_index_i,
  input  logic [mts_pkg::TEMPO_W-1:0]          cfg_wdata_i
);

  mts_pkg::cmd_t    cmd;
  mts_pkg::status_t status;

  mts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mts_datapath #(
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .operation_i    (operation_i),
    .note_index_i   (note_index_i),
    .pitch_i        (pitch_i),
    .divider_i      (divider_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .note_started_o (note_started_o),
    .tone_pitch_o   (tone_pitch_o),
    .tone_ms_o      (tone_ms_o),
    .silence_o      (silence_o),
    .playing_o      (playing_o),
    .position_o     (position_o)
  );

endmodule

// File: rtl/mts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mts_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, two quotient bits per cycle, with remainder.
// ----------------------------------------------------------------------------
module mts_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [mts_pkg::DVD_W-1:0] dividend_i,
  input  logic [mts_pkg::DSR_W-1:0] divisor_i,
  output logic                     done_o,
  output logic [mts_pkg::DVD_W-1:0] quotient_o,
  output logic [mts_pkg::DSR_W-1:0] remainder_o
);

  localparam int CNT_W = $clog2(mts_pkg::DIV_STEPS + 1);

  logic                      busy_q, done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [mts_pkg::DVD_W-1:0] quo_q, quo_d;
  logic [mts_pkg::DSR_W-1:0] rem_q, rem_d;
  logic [mts_pkg::DSR_W-1:0] dsr_q;

  logic [mts_pkg::DSR_W:0]   r1, r2, r1s, r2s;
  logic                      b1, b2;

  // Two dependent shift-subtract steps per cycle.
  always_comb begin
    r1    = {rem_q, quo_q[mts_pkg::DVD_W-1]};
    b1    = (r1 >= {1'b0, dsr_q});
    r1s   = b1 ? (r1 - {1'b0, dsr_q}) : r1;
    r2    = {r1s[mts_pkg::DSR_W-1:0], quo_q[mts_pkg::DVD_W-2]};
    b2    = (r2 >= {1'b0, dsr_q});
    r2s   = b2 ? (r2 - {1'b0, dsr_q}) : r2;
    rem_d = r2s[mts_pkg::DSR_W-1:0];
    quo_d = {quo_q[mts_pkg::DVD_W-3:0], b1, b2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(mts_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: rtl/mts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer datapath
// Configuration, request and playback registers, the note table, the shared
// divider and the result register.
// ----------------------------------------------------------------------------
module mts_datapath #(
  parameter int NOTE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mts_pkg::cmd_t                 cmd_i,
  output mts_pkg::status_t              status_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [mts_pkg::TEMPO_W-1:0]   cfg_wdata_i,
  input  logic [mts_pkg::OP_W-1:0]      operation_i,
  input  logic [mts_pkg::INDEX_W-1:0]   note_index_i,
  input  logic [mts_pkg::PITCH_W-1:0]   pitch_i,
  input  logic signed [mts_pkg::DIVIDER_W-1:0] divider_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          note_started_o,
  output logic [mts_pkg::PITCH_W-1:0]   tone_pitch_o,
  output logic [mts_pkg::MS_W-1:0]      tone_ms_o,
  output logic                          silence_o,
  output logic                          playing_o,
  output logic [mts_pkg::POS_W-1:0]     position_o
);

  localparam int AW     = $clog2(NOTE_DEPTH);
  localparam int PROD_W = mts_pkg::DVD_W + mts_pkg::RECIP_W;

  // Configuration registers.
  logic [mts_pkg::TEMPO_W-1:0] tempo_q;
  logic [mts_pkg::COUNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q <= mts_pkg::TEMPO_RESET;
      count_q <= mts_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      unique case (mts_pkg::cfg_index_e'(cfg_index_i))
        mts_pkg::CFG_TEMPO:      tempo_q <= cfg_wdata_i;
        mts_pkg::CFG_NOTE_COUNT: count_q <= cfg_wdata_i[mts_pkg::COUNT_W-1:0];
      endcase
    end
  end

  logic [mts_pkg::TEMPO_W-1:0] tempo_eff;
  logic [mts_pkg::COUNT_W-1:0] count_eff;

  always_comb begin
    tempo_eff = (tempo_q == '0) ? mts_pkg::TEMPO_W'(1) : tempo_q;
    if (count_q == '0) begin
      count_eff = mts_pkg::COUNT_W'(1);
    end else if (32'(count_q) > NOTE_DEPTH) begin
      count_eff = mts_pkg::COUNT_W'(NOTE_DEPTH);
    end else begin
      count_eff = count_q;
    end
  end

  // Latched request.
  mts_pkg::op_e                  op_q;
  logic [mts_pkg::INDEX_W-1:0]   idx_q;
  mts_pkg::note_entry_t          wr_entry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q               <= mts_pkg::op_e'(operation_i);
      idx_q              <= note_index_i;
      wr_entry_q.pitch   <= pitch_i;
      wr_entry_q.divider <= divider_i;
    end
  end

  // Playback state.
  logic                        playing_q;
  logic [mts_pkg::POS_W-1:0]   cur_q;
  logic [mts_pkg::MS_W-1:0]    elapsed_q;
  logic [mts_pkg::MS_W-1:0]    len_q;
  logic [mts_pkg::MS_W-1:0]    tone_q;
  logic                        began_q;
  mts_pkg::note_entry_t        entry_q;

  logic [mts_pkg::MS_W-1:0]    elapsed_inc;
  logic                        reached;
  logic [mts_pkg::POS_W:0]     nxt;
  logic                        mod_needed;

  logic                        div_done;
  logic [mts_pkg::DVD_W-1:0]   quo;
  logic [mts_pkg::DSR_W-1:0]   rem;
  logic [mts_pkg::DVD_W-1:0]   dvd;
  logic [mts_pkg::DSR_W-1:0]   dsr;
  logic [mts_pkg::DIVIDER_W-1:0] div_abs;
  logic [mts_pkg::MS_W-1:0]    q19;

  logic [mts_pkg::DVD_W-1:0]   tone_x9;
  logic [PROD_W-1:0]           tone_prod;
  logic [mts_pkg::MS_W-1:0]    tone_calc;

  always_comb begin
    elapsed_inc = (elapsed_q == mts_pkg::ELAPSED_MAX) ? elapsed_q
                                                      : elapsed_q + mts_pkg::MS_W'(1);
    reached     = (elapsed_inc >= len_q);
    nxt         = {1'b0, cur_q} + (mts_pkg::POS_W + 1)'(1);
    // Past the count only when the count was lowered during playback.
    mod_needed  = (nxt > count_eff);
    div_abs     = entry_q.divider[mts_pkg::DIVIDER_W-1] ? (~entry_q.divider + 1'b1)
                                                        : entry_q.divider;
    q19         = quo[mts_pkg::MS_W-1:0];
  end

  // Nine tenths of the note length, by a multiply with the scaled reciprocal.
  always_comb begin
    tone_x9   = {len_q, 3'b000} + mts_pkg::DVD_W'(len_q);
    tone_prod = PROD_W'(tone_x9) * PROD_W'(mts_pkg::TONE_RECIP);
    tone_calc = tone_prod[mts_pkg::TONE_SHIFT +: mts_pkg::MS_W];
  end

  always_comb begin
    unique case (cmd_i.dsel)
      mts_pkg::DSEL_WHOLE: begin
        dvd = mts_pkg::DVD_W'(mts_pkg::WHOLE_NOTE_MS);
        dsr = tempo_eff;
      end
      mts_pkg::DSEL_NOTE: begin
        dvd = quo;
        dsr = mts_pkg::DSR_W'(div_abs);
      end
      mts_pkg::DSEL_MOD: begin
        dvd = mts_pkg::DVD_W'(nxt);
        dsr = mts_pkg::DSR_W'(count_eff);
      end
      default: begin
        dvd = '0;
        dsr = '0;
      end
    endcase
  end

  mts_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dvd),
    .divisor_i   (dsr),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
      cur_q     <= '0;
      elapsed_q <= '0;
      len_q     <= '0;
    end else begin
      if (cmd_i.start_play) begin
        playing_q <= 1'b1;
        cur_q     <= '0;
        elapsed_q <= '0;
      end
      if (cmd_i.stop_play) begin
        playing_q <= 1'b0;
      end
      if (cmd_i.tick) begin
        if (reached) begin
          elapsed_q <= '0;
          if (!mod_needed) begin
            cur_q <= (nxt == count_eff) ? '0 : nxt[mts_pkg::POS_W-1:0];
          end
        end else begin
          elapsed_q <= elapsed_inc;
        end
      end
      if (cmd_i.mod_ld) begin
        cur_q <= rem[mts_pkg::POS_W-1:0];
      end
      if (cmd_i.len_zero) begin
        len_q <= '0;
      end
      if (cmd_i.len_ld) begin
        len_q <= entry_q.divider[mts_pkg::DIVIDER_W-1] ? (q19 + (q19 >> 1)) : q19;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      began_q <= 1'b0;
    end else if (cmd_i.entry_ld) begin
      began_q <= 1'b1;
    end
    if (cmd_i.len_zero) begin
      tone_q <= '0;
    end else if (cmd_i.tone_ld) begin
      tone_q <= tone_calc;
    end
  end

  // Note table.
  logic [AW+mts_pkg::POS_W-1:0]   raddr_wide;
  logic [AW+mts_pkg::INDEX_W-1:0] waddr_wide;
  logic                           wr_en;
  logic [mts_pkg::ENTRY_W-1:0]    rdata;

  assign raddr_wide = {{AW{1'b0}}, cur_q};
  assign waddr_wide = {{AW{1'b0}}, idx_q};
  assign wr_en      = cmd_i.ram_wr && (32'(idx_q) < NOTE_DEPTH);

  mts_ram #(
    .WIDTH (mts_pkg::ENTRY_W),
    .DEPTH (NOTE_DEPTH)
  ) u_note_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr_wide[AW-1:0]),
    .wdata_i (wr_entry_q),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (raddr_wide[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.entry_ld) begin
      entry_q <= mts_pkg::note_entry_t'(rdata);
    end
  end

  // Result register.
  logic out_valid_q;
  logic started;

  assign started = began_q && (entry_q.pitch != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_ld) begin
      note_started_o <= started;
      tone_pitch_o   <= started ? entry_q.pitch : '0;
      tone_ms_o      <= started ? tone_q : '0;
      silence_o      <= (op_q == mts_pkg::OP_STOP);
      playing_o      <= playing_q;
      position_o     <= cur_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    status_o.op         = op_q;
    status_o.playing    = playing_q;
    status_o.reached    = reached;
    status_o.mod_needed = mod_needed;
    status_o.div_zero   = (entry_q.divider == '0);
    status_o.pitch_zero = (entry_q.pitch == '0);
    status_o.div_done   = div_done;
    status_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

// File: rtl/mts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Melody tone sequencer controller
// Sequences each request through table access, divisions and result hand-off.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mts_pkg::status_t  status_i,
  output mts_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_READ,
    ST_ENTRY,
    ST_CHECK,
    ST_WHOLE,
    ST_NOTE,
    ST_TONE,
    ST_RESULT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.dsel = mts_pkg::DSEL_WHOLE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (status_i.op)
          mts_pkg::OP_WRITE: begin
            cmd_o.ram_wr = 1'b1;
            state_d      = ST_RESULT;
          end
          mts_pkg::OP_START: begin
            cmd_o.start_play = 1'b1;
            state_d          = ST_READ;
          end
          mts_pkg::OP_STOP: begin
            cmd_o.stop_play = 1'b1;
            state_d         = ST_RESULT;
          end
          mts_pkg::OP_TICK: begin
            if (!status_i.playing) begin
              state_d = ST_RESULT;
            end else begin
              cmd_o.tick = 1'b1;
              if (!status_i.reached) begin
                state_d = ST_RESULT;
              end else if (status_i.mod_needed) begin
                // Wrap through the divider when the position overshoots.
                cmd_o.div_start = 1'b1;
                cmd_o.dsel      = mts_pkg::DSEL_MOD;
                state_d         = ST_MOD;
              end else begin
                state_d = ST_READ;
              end
            end
          end
        endcase
      end
      ST_MOD: begin
        cmd_o.dsel = mts_pkg::DSEL_MOD;
        if (status_i.div_done) begin
          cmd_o.mod_ld = 1'b1;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = ST_ENTRY;
      end
      ST_ENTRY: begin
        cmd_o.entry_ld = 1'b1;
        state_d        = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.div_zero) begin
          cmd_o.len_zero = 1'b1;
          state_d        = ST_RESULT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.dsel      = mts_pkg::DSEL_WHOLE;
          state_d         = ST_WHOLE;
        end
      end
      ST_WHOLE: begin
        if (status_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.dsel      = mts_pkg::DSEL_NOTE;
          state_d         = ST_NOTE;
        end
      end
      ST_NOTE: begin
        if (status_i.div_done) begin
          cmd_o.len_ld = 1'b1;
          state_d      = status_i.pitch_zero ? ST_RESULT : ST_TONE;
        end
      end
      ST_TONE: begin
        cmd_o.tone_ld = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.result_ld = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
